// ----- hw/rtl/mwg_pkg.sv -----
// mwg_pkg: shared types, constants and helpers for the maze wall grid store.
// No dependencies; imported by every module of the block except mwg_ram.
package mwg_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 64;
    localparam int MAX_CANDIDATES = 64;

    localparam int COORD_W  = 6;
    localparam int TILE_AW  = 2 * COORD_W;
    localparam int TILE_DW  = 4;
    localparam int CAND_AW  = 6;
    localparam int CAND_DW  = 2 * COORD_W;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int RND_W    = 16;

    localparam logic [3:0] ALL_WALLS = 4'd15;
    localparam logic [2:0] WALLS_TWO   = 3'd2;
    localparam logic [2:0] WALLS_THREE = 3'd3;

    localparam logic [2:0] FUNC_SET_WALL = 3'd0;
    localparam logic [2:0] FUNC_SET_ALL  = 3'd1;
    localparam logic [2:0] FUNC_READ     = 3'd2;
    localparam logic [2:0] FUNC_PICK     = 3'd3;
    localparam logic [2:0] FUNC_FILL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd4;

    typedef struct packed {
        logic [2:0]       func;
        logic [5:0]       tile_x;
        logic [5:0]       tile_y;
        logic [1:0]       direction;
        logic             wall_value;
        logic [3:0]       wall_pattern;
        logic [RND_W-1:0] random_value;
    } mwg_in_t;

    typedef struct packed {
        logic [3:0] walls;
        logic [2:0] wall_count;
        logic [3:0] unvisited_mask;
        logic       found;
        logic [5:0] branch_x;
        logic [5:0] branch_y;
        logic       coord_error;
    } mwg_out_t;

    typedef enum logic [2:0] {
        OP_SET_WALL,
        OP_SET_ALL,
        OP_READ,
        OP_PICK,
        OP_FILL,
        OP_NOP,
        OP_ERR
    } mwg_op_t;

    typedef struct packed {
        mwg_op_t          op;
        logic [5:0]       x;
        logic [5:0]       y;
        logic [1:0]       dir;
        logic             val;
        logic [3:0]       pat;
        logic [RND_W-1:0] rnd;
    } mwg_cmd_t;

    // effective (saturated) configuration
    typedef struct packed {
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
        logic [CFG_W-1:0]   limit;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
    } mwg_cfg_t;

    typedef struct packed {
        logic clearing;
    } mwg_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SW_RD,
        ST_SW_WR,
        ST_EVAL,
        ST_EV_DONE,
        ST_SCAN,
        ST_MOD,
        ST_CAND_RD,
        ST_CAND_OUT,
        ST_DONE
    } mwg_state_t;

    function automatic logic [2:0] count_walls(input logic [3:0] w);
        count_walls = {2'b0, w[0]} + {2'b0, w[1]} + {2'b0, w[2]} + {2'b0, w[3]};
    endfunction

endpackage

// ----- hw/rtl/mwg_ram.sv -----
// mwg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mwg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/mwg_front.sv -----
// mwg_front: configuration registers and input classification.
// Depends on mwg_pkg.
module mwg_front
    import mwg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mwg_in_t              s_data,
    input  mwg_status_t          status,
    input  logic                 q_full,
    output logic                 q_push,
    output mwg_cmd_t             q_cmd,
    output mwg_cfg_t             cfg
);
    logic [CFG_W-1:0]   width_reg, height_reg, limit_reg;
    logic [COORD_W-1:0] start_x_reg, start_y_reg;
    logic               in_grid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= CFG_W'(MAX_WIDTH);
            height_reg  <= CFG_W'(MAX_HEIGHT);
            limit_reg   <= CFG_W'(MAX_CANDIDATES);
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:   width_reg   <= cfg_wr_data;
                CFG_GRID_HEIGHT:  height_reg  <= cfg_wr_data;
                CFG_BRANCH_LIMIT: limit_reg   <= cfg_wr_data;
                CFG_START_X:      start_x_reg <= cfg_wr_data[COORD_W-1:0];
                CFG_START_Y:      start_y_reg <= cfg_wr_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.width   = (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
        cfg.height  = (height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;
        if (limit_reg == '0) begin
            cfg.limit = CFG_W'(1);
        end else if (limit_reg > CFG_W'(MAX_CANDIDATES)) begin
            cfg.limit = CFG_W'(MAX_CANDIDATES);
        end else begin
            cfg.limit = limit_reg;
        end
        cfg.start_x = start_x_reg;
        cfg.start_y = start_y_reg;
    end

    assign in_grid = ({1'b0, s_data.tile_x} < cfg.width) && ({1'b0, s_data.tile_y} < cfg.height);
    assign s_ready = !q_full && !status.clearing;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.x   = s_data.tile_x;
        q_cmd.y   = s_data.tile_y;
        q_cmd.dir = s_data.direction;
        q_cmd.val = s_data.wall_value;
        q_cmd.pat = s_data.wall_pattern;
        q_cmd.rnd = s_data.random_value;
        unique case (s_data.func)
            FUNC_SET_WALL: q_cmd.op = in_grid ? OP_SET_WALL : OP_ERR;
            FUNC_SET_ALL:  q_cmd.op = in_grid ? OP_SET_ALL : OP_ERR;
            FUNC_READ:     q_cmd.op = in_grid ? OP_READ : OP_ERR;
            FUNC_PICK:     q_cmd.op = OP_PICK;
            FUNC_FILL:     q_cmd.op = OP_FILL;
            default:       q_cmd.op = OP_NOP;
        endcase
    end
endmodule

// ----- hw/rtl/mwg_queue.sv -----
// mwg_queue: two-entry command queue between front and back.
// Depends on mwg_pkg.
module mwg_queue
    import mwg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  mwg_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output mwg_cmd_t head
);
    mwg_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
endmodule

// ----- hw/rtl/mwg_back.sv -----
// mwg_back: sequencer that carries out commands on the tile store and candidate list.
// Depends on mwg_pkg and mwg_ram.
module mwg_back
    import mwg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mwg_cfg_t    cfg,
    input  logic        q_not_empty,
    input  mwg_cmd_t    q_head,
    output logic        q_pop,
    output mwg_status_t status,
    output logic        m_valid,
    input  logic        m_ready,
    output mwg_out_t    m_data
);
    mwg_state_t         state_reg, state_next;
    mwg_cmd_t           cmd_reg, cmd_next;
    logic [CFG_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [2:0]         ev_cnt_reg, ev_cnt_next;
    logic [3:0]         tile_reg, tile_next, mask_reg, mask_next;
    logic [CFG_W-1:0]   count_reg, count_next;
    logic [COORD_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [TILE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               fill_reg, fill_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [3:0]         div_cnt_reg, div_cnt_next;
    mwg_out_t           res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    mwg_out_t           m_data_reg, m_data_next;

    logic               t_we;
    logic [TILE_AW-1:0] t_waddr, t_raddr;
    logic [TILE_DW-1:0] t_wdata, t_rdata;
    logic               c_we;
    logic [CAND_AW-1:0] c_waddr, c_raddr;
    logic [CAND_DW-1:0] c_wdata, c_rdata;

    logic [COORD_W-1:0] cx, cy;
    logic [3:0]         nb_ok;
    logic [2:0]         cw;
    logic [CFG_W-1:0]   rem_shift;

    mwg_ram #(.WIDTH(TILE_DW), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_tiles (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    mwg_ram #(.WIDTH(CAND_DW), .DEPTH(MAX_CANDIDATES)) u_cands (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    assign cx = sx_reg[COORD_W-1:0];
    assign cy = sy_reg[COORD_W-1:0];
    assign nb_ok[0] = (sy_reg != '0);
    assign nb_ok[1] = (sx_reg + CFG_W'(1) < cfg.width);
    assign nb_ok[2] = (sy_reg + CFG_W'(1) < cfg.height);
    assign nb_ok[3] = (sx_reg != '0);
    assign cw = count_walls(tile_reg);
    assign rem_shift = {rem_reg[CFG_W-2:0], cmd_reg.rnd[div_cnt_reg]};
    assign c_raddr = rem_reg[CAND_AW-1:0];
    assign status.clearing = (state_reg == ST_CLEAR);
    assign q_pop = (state_reg == ST_IDLE) && q_not_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            fill_reg     <= 1'b0;
            rx_reg       <= '0;
            ry_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            fill_reg     <= fill_next;
            rx_reg       <= rx_next;
            ry_reg       <= ry_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ev_cnt_reg  <= ev_cnt_next;
        tile_reg    <= tile_next;
        mask_reg    <= mask_next;
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        ev_cnt_next   = ev_cnt_reg;
        tile_next     = tile_reg;
        mask_next     = mask_reg;
        count_next    = count_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        clr_addr_next = clr_addr_reg;
        fill_next     = fill_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        t_we    = 1'b0;
        t_waddr = {cx, cy};
        t_wdata = ALL_WALLS;
        t_raddr = {cx, cy};
        c_we    = 1'b0;
        c_waddr = count_reg[CAND_AW-1:0];
        c_wdata = {cx, cy};

        unique case (state_reg)
            ST_CLEAR: begin
                t_we          = 1'b1;
                t_waddr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + TILE_AW'(1);
                if (clr_addr_reg == '1) begin
                    fill_next  = 1'b0;
                    state_next = fill_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_not_empty) begin
                    cmd_next   = q_head;
                    res_next   = '0;
                    sx_next    = {1'b0, q_head.x};
                    sy_next    = {1'b0, q_head.y};
                    ev_cnt_next = '0;
                    count_next = '0;
                    unique case (q_head.op)
                        OP_SET_WALL: state_next = ST_SW_RD;
                        OP_SET_ALL: begin
                            t_we       = 1'b1;
                            t_waddr    = {q_head.x, q_head.y};
                            t_wdata    = q_head.pat;
                            state_next = ST_DONE;
                        end
                        OP_READ: state_next = ST_EVAL;
                        OP_PICK: begin
                            sx_next    = {1'b0, rx_reg};
                            sy_next    = {1'b0, ry_reg};
                            state_next = ST_SCAN;
                        end
                        OP_FILL: begin
                            clr_addr_next = '0;
                            fill_next     = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_ERR: begin
                            res_next.coord_error = 1'b1;
                            state_next           = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SW_RD: state_next = ST_SW_WR;
            ST_SW_WR: begin
                t_we       = 1'b1;
                t_wdata    = (t_rdata & ~(4'd1 << cmd_reg.dir))
                             | ({3'b0, cmd_reg.val} << cmd_reg.dir);
                state_next = ST_DONE;
            end
            ST_EVAL: begin
                unique case (ev_cnt_reg)
                    3'd1: t_raddr = {cx, cy - COORD_W'(1)};
                    3'd2: t_raddr = {cx + COORD_W'(1), cy};
                    3'd3: t_raddr = {cx, cy + COORD_W'(1)};
                    3'd4: t_raddr = {cx - COORD_W'(1), cy};
                    default: t_raddr = {cx, cy};
                endcase
                unique case (ev_cnt_reg)
                    3'd1: tile_next = t_rdata;
                    3'd2: mask_next[0] = nb_ok[0] && (t_rdata == ALL_WALLS);
                    3'd3: mask_next[1] = nb_ok[1] && (t_rdata == ALL_WALLS);
                    3'd4: mask_next[2] = nb_ok[2] && (t_rdata == ALL_WALLS);
                    3'd5: mask_next[3] = nb_ok[3] && (t_rdata == ALL_WALLS);
                    default: ;
                endcase
                ev_cnt_next = ev_cnt_reg + 3'd1;
                if (ev_cnt_reg == 3'd5) begin
                    state_next = ST_EV_DONE;
                end
            end
            ST_EV_DONE: begin
                if (cmd_reg.op == OP_READ) begin
                    res_next.walls          = tile_reg;
                    res_next.wall_count     = cw;
                    res_next.unvisited_mask = mask_reg;
                    state_next              = ST_DONE;
                end else begin
                    sy_next    = sy_reg + CFG_W'(1);
                    state_next = ST_SCAN;
                    if ((cw == WALLS_TWO || cw == WALLS_THREE) && mask_reg != '0) begin
                        c_we       = 1'b1;
                        count_next = count_reg + CFG_W'(1);
                        if (count_reg == '0) begin
                            rx_next = cx;
                            ry_next = cy;
                        end
                        if (count_reg + CFG_W'(1) >= cfg.limit) begin
                            rem_next     = '0;
                            div_cnt_next = 4'd15;
                            state_next   = ST_MOD;
                        end
                    end
                end
            end
            ST_SCAN: begin
                ev_cnt_next = '0;
                if (sx_reg >= cfg.width) begin
                    rem_next     = '0;
                    div_cnt_next = 4'd15;
                    state_next   = (count_reg == '0) ? ST_DONE : ST_MOD;
                end else if (sy_reg >= cfg.height) begin
                    sx_next = sx_reg + CFG_W'(1);
                    sy_next = '0;
                end else if (cx == cfg.start_x && cy == cfg.start_y) begin
                    sy_next = sy_reg + CFG_W'(1);
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_MOD: begin
                rem_next = (rem_shift >= count_reg) ? rem_shift - count_reg : rem_shift;
                div_cnt_next = div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0) begin
                    state_next = ST_CAND_RD;
                end
            end
            ST_CAND_RD: state_next = ST_CAND_OUT;
            ST_CAND_OUT: begin
                res_next.found    = 1'b1;
                res_next.branch_x = c_rdata[CAND_DW-1:COORD_W];
                res_next.branch_y = c_rdata[COORD_W-1:0];
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- hw/rtl/maze_wall_grid_store.sv -----
// Maze wall grid store: top level. A branch pick examines tiles, passes over skipped
// tiles and column changes, then does the modulo and the candidate list read. The back
// end runs one transaction at a time; a 2-entry queue lets new transactions in while
// one runs. Reset (aresetn, synchronous, active low) starts a pass that sets every
// tile to all walls; s_ready stays low meanwhile.
// Depends on mwg_pkg, mwg_front, mwg_queue, mwg_back, mwg_ram.
module maze_wall_grid_store
    import mwg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port, no read-back
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // command transactions
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mwg_in_t              s_data,
    // result transactions
    output logic                 m_valid,
    input  logic                 m_ready,
    output mwg_out_t             m_data
);
    mwg_cfg_t    cfg;
    mwg_status_t status;
    mwg_cmd_t    push_cmd, head;
    logic        push, full, pop, not_empty;

    // front: config registers, bounds check, command classification
    mwg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .status(status), .q_full(full), .q_push(push), .q_cmd(push_cmd), .cfg(cfg)
    );

    // decouples accepting transactions from executing them
    mwg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_cmd(push_cmd), .full(full),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    // back: tile store sequencer, branch scan, modulo, output register
    mwg_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_not_empty(not_empty), .q_head(head), .q_pop(pop), .status(status),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ----- hw/rtl/mwg_checker.sv -----
// mwg_checker: port-level assertions for maze_wall_grid_store, plus its bind.
// Depends on mwg_pkg.
module mwg_checker
    import mwg_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input mwg_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.coord_error |-> m_data.walls == 4'd0 && !m_data.found)
        else $error("coordinate error carries data");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.branch_x == '0 && m_data.branch_y == '0)
        else $error("branch coordinates without a find");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.wall_count == count_walls(m_data.walls))
        else $error("wall count disagrees with walls");
endmodule

bind maze_wall_grid_store mwg_checker u_mwg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
